// ----- rtl/bmf_pkg.sv -----
// Package for the box mean filter: command and status structures, controller states,
// register indexes, border mode codes and the divisor reciprocal table.
// No dependencies.
`default_nettype none

package bmf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int ROW_W      = 13;
    localparam int SUM_W      = 14;
    localparam int DELTA_W    = 4;
    localparam int DIV_K      = 18;
    localparam int DIV_M_W    = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

    localparam logic [1:0] BORDER_ZERO      = 2'd0;
    localparam logic [1:0] BORDER_REPLICATE = 2'd1;
    localparam logic [1:0] BORDER_MIRROR    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STORE,
        ST_CHECK,
        ST_ROW_MAP,
        ST_ROW_MUL,
        ST_ROW_BASE,
        ST_TAP,
        ST_FLUSH,
        ST_DIVIDE,
        ST_EMIT
    } bmf_state_t;

    typedef struct packed {
        logic capture;
        logic store;
        logic start;
        logic row_map;
        logic row_mul;
        logic row_base;
        logic tap;
        logic divide;
        logic emit;
    } bmf_cmd_t;

    typedef struct packed {
        logic result_ready;
        logic tap_last;
        logic row_last;
        logic out_free;
    } bmf_status_t;

    // Reciprocal of the tap count (2r+1)^2, rounded up, scaled by 2^DIV_K.
    function automatic logic [DIV_M_W-1:0] div_recip(input logic [1:0] r);
        logic [DIV_M_W-1:0] m;
        case (r)
            2'd0:    m = 19'd262144;
            2'd1:    m = 19'd29128;
            2'd2:    m = 19'd10486;
            2'd3:    m = 19'd5350;
            default: m = 19'd262144;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bmf_if.sv -----
// Stream interfaces for pixel requests into the filter and result requests out of it.
// Depends on nothing.
`default_nettype none

interface bmf_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_ch0;
    logic [7:0] in_ch1;
    logic [7:0] in_ch2;
    logic [7:0] in_ch3;

    modport source (output valid, action, in_ch0, in_ch1, in_ch2, in_ch3, input ready);
    modport sink   (input valid, action, in_ch0, in_ch1, in_ch2, in_ch3, output ready);
endinterface

interface bmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic [7:0] out_ch3;
    logic       frame_last;

    modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, frame_last,
                    input ready);
    modport sink   (input valid, out_ch0, out_ch1, out_ch2, out_ch3, frame_last,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/bmf_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 7168
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bmf_controller.sv -----
// Sequencer of the box mean filter: walks each request through store and readiness check,
// and a ready result through window taps, divide and emit. Depends on bmf_pkg.
`default_nettype none

module bmf_controller
    import bmf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire bmf_status_t status,
    output bmf_cmd_t         cmd
);

    bmf_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.result_ready)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_ROW_MAP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROW_MAP:
            begin
                cmd.row_map = 1'b1;
                state_next  = ST_ROW_MUL;
            end
            ST_ROW_MUL:
            begin
                cmd.row_mul = 1'b1;
                state_next  = ST_ROW_BASE;
            end
            ST_ROW_BASE:
            begin
                cmd.row_base = 1'b1;
                state_next   = ST_TAP;
            end
            ST_TAP:
            begin
                cmd.tap = 1'b1;
                if (status.tap_last)
                begin
                    state_next = status.row_last ? ST_FLUSH : ST_ROW_MAP;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.divide = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/bmf_datapath.sv -----
// Datapath of the box mean filter: configuration registers, positions, line store,
// border mapping, accumulators, divide and output register. Depends on bmf_pkg, bmf_if, bmf_ram.
`default_nettype none

module bmf_datapath
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    bmf_in_if.sink                     pix_in,
    bmf_out_if.source                  pix_out,
    input  wire bmf_cmd_t              cmd,
    output bmf_status_t                status
);

    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int CW1    = CW + 1;
    localparam int SW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH  = MAX_WINDOW * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int LIM    = (MAX_WINDOW - 1) / 2;
    localparam int MOD_K  = 20;
    localparam int MOD_M  = (2 ** MOD_K + MAX_WINDOW - 1) / MAX_WINDOW;
    localparam int MOD_MW = $clog2(MOD_M + 1);
    localparam int MOD_PW = ROW_W + MOD_MW;
    localparam int DIV_PW = SUM_W + DIV_M_W;

    // Configuration registers.
    logic [10:0] iw_reg;
    logic [12:0] ih_reg;
    logic [1:0]  wr_reg;
    logic [1:0]  bm_reg;
    logic [2:0]  cc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= 11'd1024;
            ih_reg <= 13'd1024;
            wr_reg <= 2'd1;
            bm_reg <= BORDER_ZERO;
            cc_reg <= 3'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   iw_reg <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT:  ih_reg <= cfg_data[12:0];
                CFG_WINDOW_RADIUS: wr_reg <= cfg_data[1:0];
                CFG_BORDER_MODE:   bm_reg <= cfg_data[1:0];
                CFG_CHANNEL_COUNT: cc_reg <= cfg_data[2:0];
                default:           ;
            endcase
        end
    end

    logic [CW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [1:0]       r_eff;
    logic [2:0]       nch;

    always_comb
    begin
        if (iw_reg == 11'd0)
        begin
            w_eff = CW'(1);
        end
        else if (14'(iw_reg) > 14'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(iw_reg);
        end
        h_eff = (ih_reg == 13'd0) ? 13'd1 : ih_reg;
        r_eff = (3'(wr_reg) > 3'(LIM)) ? 2'(LIM) : wr_reg;
        if (cc_reg == 3'd0)
        begin
            nch = 3'd1;
        end
        else if (cc_reg > 3'd4)
        begin
            nch = 3'd4;
        end
        else
        begin
            nch = cc_reg;
        end
    end

    // Border mapping of one axis: bit 13 flags a tap that counts, bits 12:0 the index.
    function automatic logic [13:0] map_axis(input logic signed [14:0] v,
                                             input logic [12:0] last,
                                             input logic [1:0] mode);
        logic signed [16:0] m;
        logic signed [16:0] lastx;
        logic [13:0]        res;
        lastx = $signed({4'b0000, last});
        m     = '0;
        if (v >= 0 && 17'(v) <= lastx)
        begin
            res = {1'b1, v[12:0]};
        end
        else if (mode == BORDER_REPLICATE)
        begin
            res = {1'b1, (v < 0) ? 13'd0 : last};
        end
        else if (mode == BORDER_MIRROR)
        begin
            m = (v < 0) ? -17'(v) : (lastx <<< 1) - 17'(v);
            if (m < 0)
            begin
                m = '0;
            end
            if (m > lastx)
            begin
                m = lastx;
            end
            res = {1'b1, m[12:0]};
        end
        else
        begin
            res = '0;
        end
        return res;
    endfunction

    // Captured request and stream positions.
    logic              act_reg;
    logic [31:0]       px_reg;
    logic [CW-1:0]     in_col_reg;
    logic [ROW_W-1:0]  in_row_reg;
    logic [SW-1:0]     in_slot_reg;
    logic [CW-1:0]     out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= pix_in.action;
            px_reg  <= {pix_in.in_ch3, pix_in.in_ch2, pix_in.in_ch1, pix_in.in_ch0};
        end
    end

    logic          wr_en;
    logic [CW-1:0] wr_col;
    logic [AW-1:0] wr_addr;
    logic          in_wrap;
    logic          out_col_wrap;
    logic          out_row_wrap;

    always_comb
    begin
        wr_en   = cmd.store && !act_reg && (in_row_reg < h_eff);
        wr_col  = (in_col_reg < w_eff) ? in_col_reg : w_eff - CW'(1);
        wr_addr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(wr_col);
        in_wrap = (CW1'(in_col_reg) + CW1'(1)) >= CW1'(w_eff);
        out_col_wrap = (CW1'(out_col_reg) + CW1'(1)) >= CW1'(w_eff);
        out_row_wrap = (14'(out_row_reg) + 14'd1) >= 14'(h_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_slot_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (wr_en)
        begin
            if (in_wrap)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= in_row_reg + 13'd1;
                in_slot_reg <= (in_slot_reg == SW'(MAX_WINDOW - 1)) ? '0 : in_slot_reg + SW'(1);
            end
            else
            begin
                in_col_reg <= in_col_reg + CW'(1);
            end
        end
        else if (cmd.emit)
        begin
            if (out_col_wrap)
            begin
                out_col_reg <= '0;
                if (out_row_wrap)
                begin
                    out_row_reg <= '0;
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    in_slot_reg <= '0;
                end
                else
                begin
                    out_row_reg <= out_row_reg + 13'd1;
                end
            end
            else
            begin
                out_col_reg <= out_col_reg + CW'(1);
            end
        end
    end

    // A result may leave once the input has passed the lower right corner of its window.
    logic [13:0]    ry;
    logic [CW1-1:0] cx;
    logic           res_ready;

    always_comb
    begin
        ry = 14'(out_row_reg) + 14'(r_eff);
        if (ry > 14'(h_eff - 13'd1))
        begin
            ry = 14'(h_eff - 13'd1);
        end
        cx = CW1'(out_col_reg) + CW1'(r_eff);
        if (cx > CW1'(w_eff - CW'(1)))
        begin
            cx = CW1'(w_eff - CW'(1));
        end
        res_ready = (in_row_reg >= h_eff) || (14'(in_row_reg) > ry)
                    || ((14'(in_row_reg) == ry) && (CW1'(in_col_reg) > cx));
    end

    // Window walk.
    logic signed [DELTA_W-1:0] dy_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] r_signed;
    logic [ROW_W-1:0]          y_reg;
    logic                      row_ok_reg;
    logic [ROW_W-1:0]          q_reg;
    logic [AW-1:0]             base_reg;
    logic                      pend_reg;
    logic [13:0]               ymap;
    logic [13:0]               xmap;
    logic [MOD_PW-1:0]         y_prod;
    logic [ROW_W-1:0]          slot;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [31:0]               rd_data;

    always_comb
    begin
        r_signed = $signed({2'b00, r_eff});
        ymap     = map_axis($signed({2'b00, out_row_reg}) + 15'(dy_reg), h_eff - 13'd1, bm_reg);
        xmap     = map_axis($signed(15'(out_col_reg)) + 15'(dx_reg),
                            13'(w_eff - CW'(1)), bm_reg);
        y_prod   = MOD_PW'(y_reg) * MOD_PW'(MOD_M);
        slot     = y_reg - q_reg * 13'(MAX_WINDOW);
        rd_en    = cmd.tap && row_ok_reg && xmap[13];
        rd_addr  = base_reg + AW'(xmap[CW-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dy_reg <= -r_signed;
        end
        else if (cmd.tap && (dx_reg == r_signed))
        begin
            dy_reg <= dy_reg + DELTA_W'(1);
        end
        if (cmd.row_base)
        begin
            dx_reg <= -r_signed;
        end
        else if (cmd.tap)
        begin
            dx_reg <= dx_reg + DELTA_W'(1);
        end
        if (cmd.row_map)
        begin
            y_reg      <= ymap[12:0];
            row_ok_reg <= ymap[13];
        end
        if (cmd.row_mul)
        begin
            q_reg <= ROW_W'(y_prod >> MOD_K);
        end
        if (cmd.row_base)
        begin
            base_reg <= AW'(SW'(slot)) * AW'(MAX_WIDTH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= rd_en;
        end
    end

    bmf_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_line_store (
        .clk  (clk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(px_reg),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // Per-channel sums and the divide by the tap count.
    logic [SUM_W-1:0]   acc_reg [4];
    logic [7:0]         quo_reg [4];
    logic [DIV_M_W-1:0] recip;
    logic [DIV_PW-1:0]  div_prod [4];

    always_comb
    begin
        recip = div_recip(r_eff);
        for (int c = 0; c < 4; c++)
        begin
            div_prod[c] = DIV_PW'(acc_reg[c]) * DIV_PW'(recip);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (cmd.start)
            begin
                acc_reg[c] <= '0;
            end
            else if (pend_reg)
            begin
                acc_reg[c] <= acc_reg[c] + SUM_W'(rd_data[8*c +: 8]);
            end
            if (cmd.divide)
            begin
                quo_reg[c] <= div_prod[c][DIV_K +: 8];
            end
        end
    end

    // Output register.
    logic       out_valid_reg;
    logic [7:0] out_ch_reg [4];
    logic       out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            for (int c = 0; c < 4; c++)
            begin
                out_ch_reg[c] <= (3'(c) < nch) ? quo_reg[c] : 8'd0;
            end
            out_last_reg <= out_col_wrap && out_row_wrap;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.out_ch0    = out_ch_reg[0];
    assign pix_out.out_ch1    = out_ch_reg[1];
    assign pix_out.out_ch2    = out_ch_reg[2];
    assign pix_out.out_ch3    = out_ch_reg[3];
    assign pix_out.frame_last = out_last_reg;

    assign status.result_ready = res_ready;
    assign status.tap_last     = (dx_reg == r_signed);
    assign status.row_last     = (dy_reg == r_signed);
    assign status.out_free     = !out_valid_reg || pix_out.ready;

endmodule

`default_nettype wire

// ----- rtl/box_mean_filter_border_modes_top.sv -----
// Top level of the box mean filter with border extension.
// Depends on bmf_pkg, bmf_if, bmf_controller, bmf_datapath and bmf_ram.
`default_nettype none

// The block takes a raster-order pixel stream of up to four byte channels and returns,
// for every pixel position, the floor of the mean over a square window of side 2r+1,
// with samples beyond the image edge taken as zero, as the nearest edge pixel, or
// mirrored about the edge without repeating it. A drain request (action set) releases
// one pending result after the frame input is complete; a pixel request releases one
// result as soon as its window has arrived. Requests are handled one at a time: a
// request that releases a result walks every window tap in turn, paced by the single
// read port of the line store, which is read at most once for every window tap, and
// by setup steps per window row that map the row through the border rule, reduce it
// modulo the number of stored rows and form its base address. The next request is
// taken while a finished result still waits in the output register; the emit step
// waits only if that register is still full. The line store holds the last
// MAX_WINDOW rows and needs no clearing after reset; configuration must be written
// only between frames or while the block is idle, which the block does not enforce.
module box_mean_filter_border_modes_top
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    bmf_in_if.sink                     pix_in,
    bmf_out_if.source                  pix_out
);

    bmf_cmd_t    cmd;
    bmf_status_t status;
    logic        in_ready;

    // The controller alone decides when a request is taken.
    assign pix_in.ready = in_ready;

    bmf_controller u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(pix_in.valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bmf_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pix_in   (pix_in),
        .pix_out  (pix_out),
        .cmd      (cmd),
        .status   (status)
    );

    // A taken request is always stored in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready) |=> cmd.store)
        else $error("accepted request was not stored");

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!pix_out.valid || pix_out.ready))
        else $error("output register overwritten");

    // After the final tap the read pipeline drains before any further tap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tap && status.tap_last && status.row_last) |=> !cmd.tap && !pix_in.ready)
        else $error("window walk did not finish cleanly");

endmodule

`default_nettype wire
